>>> rtl/core/tilt_orientation_and_motion_qualifier_macros.svh
// Assertion macros for the tilt orientation and motion qualifier.
// Used by the checker that is bound to the top level; no other dependencies.
`ifndef TILT_ORIENTATION_AND_MOTION_QUALIFIER_MACROS_SVH
`define TILT_ORIENTATION_AND_MOTION_QUALIFIER_MACROS_SVH

// Property checked on every clock edge while reset is released.
`define TOMQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property failed");

// Property checked on every clock edge, reset included.
`define TOMQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: property failed");

`endif

>>> rtl/core/tomq_pkg.sv
// Shared types and constants of the tilt orientation and motion qualifier.
// No dependencies; every other file but the assertion macro header imports it.
package tomq_pkg;

    localparam int TRIG_W   = 15;
    localparam int STABLE_W = 16;
    localparam int MOTION_W = 18;
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_UPRIGHT_INVERT   = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_LEVEL    = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STABLE_TIME      = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MOTION_THRESHOLD = 8'd3;

    localparam logic [TRIG_W-1:0]   TRIGGER_LEVEL_RST    = 15'd500;
    localparam logic [STABLE_W-1:0] STABLE_TIME_RST      = 16'd500;
    localparam logic [MOTION_W-1:0] MOTION_THRESHOLD_RST = 18'd100;

    typedef logic [1:0] t_rotation;

    localparam t_rotation ROT_0   = 2'd0;
    localparam t_rotation ROT_90  = 2'd1;
    localparam t_rotation ROT_180 = 2'd2;
    localparam t_rotation ROT_270 = 2'd3;

    typedef struct packed {
        logic                upright_invert;
        logic [TRIG_W-1:0]   trigger_level;
        logic [STABLE_W-1:0] stable_time;
        logic [MOTION_W-1:0] motion_threshold;
    } t_cfg;

endpackage

>>> rtl/core/tomq_if.sv
// Valid/ready channel interfaces: sample requests, result requests and
// configuration writes. Depends on tomq_pkg.
interface tomq_smp_if import tomq_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int TIME_BITS   = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
    logic [TIME_BITS-1:0]          now_ms;
    logic                          screen_asleep;

    modport source (output valid, accel_x, accel_y, accel_z, now_ms, screen_asleep,
                    input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, now_ms, screen_asleep,
                    output ready);
endinterface

interface tomq_res_if import tomq_pkg::*;;
    logic      valid;
    logic      ready;
    t_rotation rotation;
    logic      rotation_changed;
    logic      wake;

    modport source (output valid, rotation, rotation_changed, wake, input ready);
    modport sink   (input valid, rotation, rotation_changed, wake, output ready);
endinterface

interface tomq_cfg_if import tomq_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/tomq_orient.sv
// Rotation classifier with debounce: candidate, stable timer, shown rotation.
// Depends on tomq_pkg.
module tomq_orient import tomq_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_update,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [SAMPLE_BITS-1:0] i_y,
    input  logic [TIME_BITS-1:0]          i_now,
    input  t_cfg                          i_cfg,
    output t_rotation                     o_rotation,
    output logic                          o_changed
);
    localparam int UW = SAMPLE_BITS + 1;
    localparam int CW = (UW > TRIG_W) ? UW : TRIG_W;

    t_rotation            r_shown;
    logic                 r_pending_valid;
    t_rotation            r_pending_rot;
    logic [TIME_BITS-1:0] r_pending_since;

    t_rotation            n_shown;
    logic                 n_pending_valid;
    t_rotation            n_pending_rot;
    logic [TIME_BITS-1:0] n_pending_since;

    logic signed [UW-1:0] w_x_ext;
    logic signed [UW-1:0] w_u;
    logic [UW-1:0]        w_au;
    logic [UW-1:0]        w_ay;
    logic [UW-1:0]        w_dom;
    logic                 w_triggered;
    t_rotation            w_cand;
    logic [TIME_BITS-1:0] w_elapsed;

    // One extra bit keeps the negation of the most negative sample exact.
    assign w_x_ext = {i_x[SAMPLE_BITS-1], i_x};
    assign w_u     = i_cfg.upright_invert ? -w_x_ext : w_x_ext;
    assign w_au    = w_u[UW-1] ? UW'(-w_u) : UW'(w_u);
    assign w_ay    = i_y[SAMPLE_BITS-1] ? UW'(-{i_y[SAMPLE_BITS-1], i_y})
                                        : UW'({i_y[SAMPLE_BITS-1], i_y});
    assign w_dom   = (w_au > w_ay) ? w_au : w_ay;
    assign w_triggered = CW'(w_dom) >= CW'(i_cfg.trigger_level);
    assign w_elapsed   = i_now - r_pending_since;

    always_comb begin
        if (w_au >= w_ay) begin
            w_cand = w_u[UW-1] ? ROT_180 : ROT_0;
        end else begin
            w_cand = (i_y[SAMPLE_BITS-1] || (i_y == '0)) ? ROT_270 : ROT_90;
        end
    end

    always_comb begin
        n_shown         = r_shown;
        n_pending_valid = r_pending_valid;
        n_pending_rot   = r_pending_rot;
        n_pending_since = r_pending_since;
        o_changed       = 1'b0;
        if (!w_triggered) begin
            n_pending_valid = 1'b0;
        end else if (!r_pending_valid || (w_cand != r_pending_rot)) begin
            n_pending_valid = 1'b1;
            n_pending_rot   = w_cand;
            n_pending_since = i_now;
        end else if ((w_cand != r_shown) &&
                     (w_elapsed >= TIME_BITS'(i_cfg.stable_time))) begin
            n_shown   = w_cand;
            o_changed = 1'b1;
        end
        o_rotation = n_shown;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown         <= ROT_0;
            r_pending_valid <= 1'b0;
        end else if (i_update) begin
            r_shown         <= n_shown;
            r_pending_valid <= n_pending_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_update) begin
            r_pending_rot   <= n_pending_rot;
            r_pending_since <= n_pending_since;
        end
    end

endmodule

>>> rtl/core/tomq_motion.sv
// Motion detector: summed absolute axis change against the wake threshold.
// Depends on tomq_pkg.
module tomq_motion import tomq_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_update,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [SAMPLE_BITS-1:0] i_y,
    input  logic signed [SAMPLE_BITS-1:0] i_z,
    input  logic                          i_asleep,
    input  t_cfg                          i_cfg,
    output logic                          o_wake
);
    localparam int DW = SAMPLE_BITS + 1;
    localparam int SW = (SAMPLE_BITS + 3 > MOTION_W) ? SAMPLE_BITS + 3 : MOTION_W;

    logic                          r_prior_valid;
    logic signed [SAMPLE_BITS-1:0] r_prior_x;
    logic signed [SAMPLE_BITS-1:0] r_prior_y;
    logic signed [SAMPLE_BITS-1:0] r_prior_z;

    logic signed [DW-1:0] w_dx;
    logic signed [DW-1:0] w_dy;
    logic signed [DW-1:0] w_dz;
    logic [DW-1:0]        w_ax;
    logic [DW-1:0]        w_ay;
    logic [DW-1:0]        w_az;
    logic [SW-1:0]        w_sum;

    assign w_dx = {i_x[SAMPLE_BITS-1], i_x} - {r_prior_x[SAMPLE_BITS-1], r_prior_x};
    assign w_dy = {i_y[SAMPLE_BITS-1], i_y} - {r_prior_y[SAMPLE_BITS-1], r_prior_y};
    assign w_dz = {i_z[SAMPLE_BITS-1], i_z} - {r_prior_z[SAMPLE_BITS-1], r_prior_z};
    assign w_ax = w_dx[DW-1] ? DW'(-w_dx) : DW'(w_dx);
    assign w_ay = w_dy[DW-1] ? DW'(-w_dy) : DW'(w_dy);
    assign w_az = w_dz[DW-1] ? DW'(-w_dz) : DW'(w_dz);
    assign w_sum = SW'(w_ax) + SW'(w_ay) + SW'(w_az);

    // The first sample after reset only fills the prior-sample store.
    assign o_wake = r_prior_valid && i_asleep && (w_sum >= SW'(i_cfg.motion_threshold));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior_valid <= 1'b0;
        end else if (i_update) begin
            r_prior_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_update) begin
            r_prior_x <= i_x;
            r_prior_y <= i_y;
            r_prior_z <= i_z;
        end
    end

endmodule

>>> rtl/core/tilt_orientation_and_motion_qualifier.sv
// Top level of the tilt orientation and motion qualifier.
// Depends on tomq_pkg, tomq_if, tomq_orient and tomq_motion.
//
//  Channel   Dir  Payload                                       Handshake
//  i_smp     in   accel_x/y/z, now_ms, screen_asleep            valid/ready
//  o_res     out  rotation, rotation_changed, wake              valid/ready
//  i_cfg     in   index, data (register write)                  valid/ready
//
// A sample request is registered in the input register, evaluated combinationally with
// the state update and registered as a result in the result register; one sample per
// cycle is sustained while o_res.ready is high.
// Synchronous active-low reset clears the pipeline, the state and the registers to
// their defaults. When the result is stalled, one more sample is held in the input
// register and then i_smp.ready drops. Configuration writes are always accepted.
module tilt_orientation_and_motion_qualifier import tomq_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tomq_smp_if.sink   i_smp,
    tomq_res_if.source o_res,
    tomq_cfg_if.sink   i_cfg
);
    t_cfg r_cfg;

    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_in_x;
    logic signed [SAMPLE_BITS-1:0] r_in_y;
    logic signed [SAMPLE_BITS-1:0] r_in_z;
    logic [TIME_BITS-1:0]          r_in_now;
    logic                          r_in_asleep;

    logic      r_out_valid;
    t_rotation r_out_rotation;
    logic      r_out_changed;
    logic      r_out_wake;

    logic      n_in_valid;
    logic      n_out_valid;
    logic      w_accept;
    logic      w_advance;
    t_rotation w_rotation;
    logic      w_changed;
    logic      w_wake;

    assign w_advance   = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_smp.ready = !r_in_valid || w_advance;
    assign w_accept    = i_smp.valid && i_smp.ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_x      <= i_smp.accel_x;
            r_in_y      <= i_smp.accel_y;
            r_in_z      <= i_smp.accel_z;
            r_in_now    <= i_smp.now_ms;
            r_in_asleep <= i_smp.screen_asleep;
        end
        if (w_advance) begin
            r_out_rotation <= w_rotation;
            r_out_changed  <= w_changed;
            r_out_wake     <= w_wake;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.upright_invert   <= 1'b0;
            r_cfg.trigger_level    <= TRIGGER_LEVEL_RST;
            r_cfg.stable_time      <= STABLE_TIME_RST;
            r_cfg.motion_threshold <= MOTION_THRESHOLD_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_UPRIGHT_INVERT: begin
                    r_cfg.upright_invert <= i_cfg.data[0];
                end
                REG_TRIGGER_LEVEL: begin
                    r_cfg.trigger_level <= i_cfg.data[TRIG_W-1:0];
                end
                REG_STABLE_TIME: begin
                    r_cfg.stable_time <= i_cfg.data[STABLE_W-1:0];
                end
                REG_MOTION_THRESHOLD: begin
                    r_cfg.motion_threshold <= i_cfg.data[MOTION_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    tomq_orient #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_orient (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_update   (w_advance),
        .i_x        (r_in_x),
        .i_y        (r_in_y),
        .i_now      (r_in_now),
        .i_cfg      (r_cfg),
        .o_rotation (w_rotation),
        .o_changed  (w_changed)
    );

    tomq_motion #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_motion (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (w_advance),
        .i_x      (r_in_x),
        .i_y      (r_in_y),
        .i_z      (r_in_z),
        .i_asleep (r_in_asleep),
        .i_cfg    (r_cfg),
        .o_wake   (w_wake)
    );

    assign o_res.valid            = r_out_valid;
    assign o_res.rotation         = r_out_rotation;
    assign o_res.rotation_changed = r_out_changed;
    assign o_res.wake             = r_out_wake;

endmodule

>>> rtl/core/tomq_checker.sv
// Port-level checks of the tilt orientation and motion qualifier, bound to the top.
// Depends on tomq_pkg and the assertion macro header.
`include "tilt_orientation_and_motion_qualifier_macros.svh"

module tomq_checker import tomq_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_rotation i_out_rotation,
    input logic      i_out_changed,
    input logic      i_out_wake
);
    // Requests inside the block: at most one in the input and one in the result stage.
    logic [1:0] r_inflight;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 2'd0;
        end else begin
            r_inflight <= r_inflight + 2'(w_in_acc) - 2'(w_out_acc);
        end
    end

    `TOMQ_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !i_out_valid)
    `TOMQ_ASSERT(a_no_result_from_nothing, i_clk, i_rst_n, i_out_valid |-> r_inflight != 2'd0)
    `TOMQ_ASSERT(a_inflight_bound, i_clk, i_rst_n, r_inflight != 2'd3)
    `TOMQ_ASSERT(a_full_blocks_input, i_clk, i_rst_n, r_inflight == 2'd2 && !i_out_ready |-> !i_in_ready)
    `TOMQ_ASSERT(a_stall_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_rotation) && $stable(i_out_changed) && $stable(i_out_wake))

endmodule

bind tilt_orientation_and_motion_qualifier tomq_checker u_tomq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_smp.valid),
    .i_in_ready     (i_smp.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_rotation (o_res.rotation),
    .i_out_changed  (o_res.rotation_changed),
    .i_out_wake     (o_res.wake)
);

>>> tb/tb.sv
// Self-checking testbench for the tilt orientation and motion qualifier.
// Drives sample requests and register writes, and checks every result request.
// Depends on tomq_pkg, the channel interfaces in tomq_if and the top level.
module tb;
    import tomq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SMP_W  = 16;
    localparam int TIME_W = 32;

    // Indexes with no register behind them; writes there must change nothing.
    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED_LOW  = 8'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED_HIGH = 8'hFF;

    typedef struct packed {
        logic signed [SMP_W-1:0] x;
        logic signed [SMP_W-1:0] y;
        logic signed [SMP_W-1:0] z;
        logic [TIME_W-1:0]       now_ms;
        logic                    asleep;
    } t_sample;

    typedef struct packed {
        t_rotation rotation;
        logic      changed;
        logic      wake;
    } t_orient_result;

    typedef struct packed {
        t_sample        smp;
        logic           known;
        t_orient_result want;
    } t_stim_row;

    // Reset register values apply throughout this table.
    localparam t_stim_row DIRECTED [25] = '{
        '{'{16'sd0,      16'sd0,      16'sd0,      32'h0000_0000, 1'b1}, 1'b1, '{ROT_0,   1'b0, 1'b0}},
        '{'{16'sd32767,  16'sd0,      16'sd0,      32'd10,        1'b1}, 1'b1, '{ROT_0,   1'b0, 1'b1}},
        '{'{16'sh8000,   16'sd0,      16'sh8000,   32'd20,        1'b0}, 1'b1, '{ROT_0,   1'b0, 1'b0}},
        '{'{16'sh8000,   16'sd0,      16'sh8000,   32'd519,       1'b0}, 1'b1, '{ROT_0,   1'b0, 1'b0}},
        '{'{16'sh8000,   16'sd0,      16'sh8000,   32'd520,       1'b1}, 1'b1, '{ROT_180, 1'b1, 1'b0}},
        '{'{16'sh8000,   16'sd0,      16'sh8000,   32'd9000,      1'b1}, 1'b1, '{ROT_180, 1'b0, 1'b0}},
        '{'{16'sd0,      16'sd32767,  16'sd32767,  32'd9010,      1'b1}, 1'b1, '{ROT_180, 1'b0, 1'b1}},
        '{'{16'sd0,      16'sd32767,  16'sd32767,  32'd9510,      1'b1}, 1'b1, '{ROT_90,  1'b1, 1'b0}},
        '{'{16'sd0,      16'sh8000,   16'sd0,      32'hFFFF_FF00, 1'b0}, 1'b1, '{ROT_90,  1'b0, 1'b0}},
        '{'{16'sd0,      16'sh8000,   16'sd0,      32'h0000_00F4, 1'b0}, 1'b1, '{ROT_270, 1'b1, 1'b0}},
        '{'{16'sd499,    -16'sd499,   16'sd0,      32'h0000_1000, 1'b1}, 1'b1, '{ROT_270, 1'b0, 1'b1}},
        '{'{16'sd0,      -16'sd500,   16'sd0,      32'h0000_1010, 1'b1}, 1'b1, '{ROT_270, 1'b0, 1'b1}},
        '{'{16'sd0,      -16'sd500,   16'sd0,      32'h0000_2000, 1'b1}, 1'b1, '{ROT_270, 1'b0, 1'b0}},
        '{'{16'sd600,    16'sd600,    16'sd0,      32'h0000_2010, 1'b1}, 1'b1, '{ROT_270, 1'b0, 1'b1}},
        '{'{16'sd600,    -16'sd600,   16'sd0,      32'h0000_2200, 1'b1}, 1'b1, '{ROT_270, 1'b0, 1'b1}},
        '{'{16'sd601,    -16'sd600,   16'sd50,     32'h0000_2204, 1'b1}, 1'b1, '{ROT_0,   1'b1, 1'b0}},
        '{'{16'sd601,    -16'sd600,   16'sd149,    32'h0000_2300, 1'b1}, 1'b1, '{ROT_0,   1'b0, 1'b0}},
        '{'{16'sd601,    -16'sd600,   16'sd249,    32'h0000_2301, 1'b1}, 1'b1, '{ROT_0,   1'b0, 1'b1}},
        '{'{16'sd601,    -16'sd600,   16'sd349,    32'h0000_2302, 1'b0}, 1'b1, '{ROT_0,   1'b0, 1'b0}},
        '{'{-16'sd700,   16'sd100,    16'sd0,      32'h0000_2400, 1'b1}, 1'b0, '0},
        '{'{-16'sd700,   -16'sd699,   16'sd0,      32'h0000_2500, 1'b1}, 1'b0, '0},
        '{'{-16'sd100,   16'sd32000,  -16'sd5,     32'h7FFF_FFFF, 1'b1}, 1'b0, '0},
        '{'{16'sd32767,  16'sh8000,   16'sd32767,  32'h8000_0000, 1'b0}, 1'b0, '0},
        '{'{16'sd32767,  16'sh8000,   16'sh8000,   32'h8000_01F4, 1'b1}, 1'b0, '0},
        '{'{16'sd0,      16'sd0,      16'sd0,      32'hFFFF_FFFF, 1'b1}, 1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    tomq_smp_if #(.SAMPLE_BITS(SMP_W), .TIME_BITS(TIME_W)) smp_ch ();
    tomq_res_if res_ch ();
    tomq_cfg_if cfg_ch ();

    tilt_orientation_and_motion_qualifier #(
        .SAMPLE_BITS(SMP_W),
        .TIME_BITS  (TIME_W)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_smp  (smp_ch),
        .o_res  (res_ch),
        .i_cfg  (cfg_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predictor copy of the registers and the orientation and motion state.
    t_cfg              model_cfg;
    t_rotation         shown_rot;
    bit                pend_valid;
    t_rotation         pend_rot;
    logic [TIME_W-1:0] pend_since;
    bit                prior_seen;
    int                prior_x;
    int                prior_y;
    int                prior_z;

    t_orient_result    awaited_results [$];
    int                errors;
    logic [TIME_W-1:0] stamp_ms;
    bit                calm;
    int                hold_stretch;

    task automatic report_mismatch(input string what);
        $display("tb: mismatch at %0t ns: %s", $time, what);
        errors++;
    endtask

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic t_orient_result advance_orientation(input t_sample s);
        int xv, yv, zv, u, au, ay, dom, delta, trig, thresh;
        t_rotation cand;
        logic [TIME_W-1:0] elapsed;
        t_orient_result r;
        xv = s.x;
        yv = s.y;
        zv = s.z;
        trig = model_cfg.trigger_level;
        thresh = model_cfg.motion_threshold;
        u = model_cfg.upright_invert ? -xv : xv;
        au = magnitude(u);
        ay = magnitude(yv);
        dom = (au > ay) ? au : ay;
        r = '0;
        if (dom < trig) begin
            pend_valid = 1'b0;
        end else begin
            if (au >= ay) cand = (u >= 0) ? ROT_0 : ROT_180;
            else cand = (yv <= 0) ? ROT_270 : ROT_90;
            if (!pend_valid || cand != pend_rot) begin
                pend_valid = 1'b1;
                pend_rot = cand;
                pend_since = s.now_ms;
            end else begin
                elapsed = s.now_ms - pend_since;
                if (cand != shown_rot && elapsed >= model_cfg.stable_time) begin
                    shown_rot = cand;
                    r.changed = 1'b1;
                end
            end
        end
        if (prior_seen) begin
            delta = magnitude(xv - prior_x) + magnitude(yv - prior_y) + magnitude(zv - prior_z);
            if (s.asleep && delta >= thresh) r.wake = 1'b1;
        end
        prior_x = xv;
        prior_y = yv;
        prior_z = zv;
        prior_seen = 1'b1;
        r.rotation = shown_rot;
        return r;
    endfunction

    // Timestamps mostly creep forward on the scale of the stable time, with
    // occasional jumps anywhere and runs just short of the wrap.
    function automatic logic [TIME_W-1:0] next_stamp();
        int step_max;
        step_max = model_cfg.stable_time / 2 + 40;
        case ($urandom_range(0, 15))
            0: stamp_ms = $urandom;
            1: stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 600);
            default: stamp_ms = stamp_ms + $urandom_range(0, step_max);
        endcase
        return stamp_ms;
    endfunction

    function automatic logic signed [SMP_W-1:0] signed_within(input int m);
        int v;
        v = $urandom_range(m, 0);
        if ($urandom_range(0, 1) == 1) v = -v;
        return v[SMP_W-1:0];
    endfunction

    // A sample that classifies as rotation r under the current registers.
    function automatic t_sample shape_sample(input t_rotation r);
        int lo, m, top, u, yv, xv;
        t_sample s;
        lo = model_cfg.trigger_level;
        if (lo < 1) lo = 1;
        top = (r == ROT_180 || r == ROT_270) ? 32768 : 32767;
        m = $urandom_range(top, lo);
        u = 0;
        yv = 0;
        case (r)
            ROT_0:   begin u = m;  yv = signed_within(m); end
            ROT_180: begin u = -m; yv = signed_within(m); end
            ROT_90:  begin yv = m;  u = signed_within(m - 1); end
            default: begin yv = -m; u = signed_within(m - 1); end
        endcase
        xv = model_cfg.upright_invert ? -u : u;
        s.x = xv[SMP_W-1:0];
        s.y = yv[SMP_W-1:0];
        s.z = SMP_W'($urandom);
        s.now_ms = next_stamp();
        s.asleep = 1'($urandom);
        return s;
    endfunction

    task automatic offer_sample(input t_sample s, input bit known, input t_orient_result want);
        t_orient_result calc;
        int gap;
        smp_ch.valid <= 1'b1;
        smp_ch.accel_x <= s.x;
        smp_ch.accel_y <= s.y;
        smp_ch.accel_z <= s.z;
        smp_ch.now_ms <= s.now_ms;
        smp_ch.screen_asleep <= s.asleep;
        do @(posedge i_clk); while (!smp_ch.ready);
        calc = advance_orientation(s);
        awaited_results.push_back(known ? want : calc);
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            smp_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    // Writes all four registers back to back, then two unmapped indexes.
    // Upper data bits carry noise that the register widths must discard.
    task automatic program_registers(input t_cfg c);
        logic [CFG_ADDR_W-1:0] idx [6];
        logic [CFG_DATA_W-1:0] val [6];
        idx = '{REG_UPRIGHT_INVERT, REG_TRIGGER_LEVEL, REG_STABLE_TIME,
                REG_MOTION_THRESHOLD, REG_UNMAPPED_LOW, REG_UNMAPPED_HIGH};
        foreach (val[i]) val[i] = $urandom;
        val[0][0] = c.upright_invert;
        val[1][TRIG_W-1:0] = c.trigger_level;
        val[2][STABLE_W-1:0] = c.stable_time;
        val[3][MOTION_W-1:0] = c.motion_threshold;
        for (int i = 0; i < 6; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data <= val[i];
            do @(posedge i_clk); while (!cfg_ch.ready);
            case (idx[i])
                REG_UPRIGHT_INVERT:   model_cfg.upright_invert = val[i][0];
                REG_TRIGGER_LEVEL:    model_cfg.trigger_level = val[i][TRIG_W-1:0];
                REG_STABLE_TIME:      model_cfg.stable_time = val[i][STABLE_W-1:0];
                REG_MOTION_THRESHOLD: model_cfg.motion_threshold = val[i][MOTION_W-1:0];
                default: ;
            endcase
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(input t_cfg c, input int items, input bit squeeze);
        t_sample s;
        t_rotation r;
        int done, len, m, trig;
        bit squeezed;
        program_registers(c);
        done = 0;
        squeezed = 1'b0;
        trig = model_cfg.trigger_level;
        while (done < items) begin
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) == 0) begin
                s.x = SMP_W'($urandom);
                s.y = SMP_W'($urandom);
                s.z = SMP_W'($urandom);
                s.now_ms = next_stamp();
                s.asleep = 1'($urandom);
                offer_sample(s, 1'b0, '0);
                done++;
            end else if (trig > 0 && $urandom_range(0, 7) == 0) begin
                // Below the trigger level: clears any candidate.
                m = $urandom_range(trig - 1, 0);
                s.x = signed_within(m);
                s.y = signed_within(m);
                s.z = SMP_W'($urandom);
                s.now_ms = next_stamp();
                s.asleep = 1'($urandom);
                offer_sample(s, 1'b0, '0);
                done++;
            end else begin
                r = t_rotation'($urandom_range(0, 3));
                len = $urandom_range(1, 6);
                repeat (len) begin
                    offer_sample(shape_sample(r), 1'b0, '0);
                    done++;
                end
            end
            if (squeeze && !squeezed && done >= 30) begin
                hold_stretch = 60;
                squeezed = 1'b1;
            end
        end
        calm = 1'b0;
        smp_ch.valid <= 1'b0;
        drain_results();
    endtask

    always @(posedge i_clk) begin : result_check
        t_orient_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result request with nothing outstanding");
            end else begin
                want = awaited_results.pop_front();
                if (res_ch.rotation !== want.rotation)
                    report_mismatch($sformatf("rotation %0d, wanted %0d",
                                              res_ch.rotation, want.rotation));
                if (res_ch.rotation_changed !== want.changed)
                    report_mismatch($sformatf("rotation_changed %b, wanted %b",
                                              res_ch.rotation_changed, want.changed));
                if (res_ch.wake !== want.wake)
                    report_mismatch($sformatf("wake %b, wanted %b", res_ch.wake, want.wake));
            end
        end
    end

    // Result side: random stalls per request, and the occasional long hold-off
    // that lets the block fill up and push back on the sample channel.
    initial begin : result_sink
        int pause;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_stretch > 0) begin
                pause = hold_stretch;
                hold_stretch = 0;
            end else if (calm) begin
                pause = 0;
            end else begin
                pause = $urandom_range(0, 3);
            end
            if (pause > 0) begin
                res_ch.ready <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        t_cfg phase_cfg [6];
        errors = 0;
        calm = 1'b0;
        hold_stretch = 0;
        stamp_ms = '0;
        model_cfg = '{1'b0, TRIGGER_LEVEL_RST, STABLE_TIME_RST, MOTION_THRESHOLD_RST};
        shown_rot = ROT_0;
        pend_valid = 1'b0;
        pend_rot = ROT_0;
        pend_since = '0;
        prior_seen = 1'b0;
        prior_x = 0;
        prior_y = 0;
        prior_z = 0;

        i_rst_n <= 1'b0;
        smp_ch.valid <= 1'b0;
        smp_ch.accel_x <= '0;
        smp_ch.accel_y <= '0;
        smp_ch.accel_z <= '0;
        smp_ch.now_ms <= '0;
        smp_ch.screen_asleep <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i]) offer_sample(DIRECTED[i].smp, DIRECTED[i].known, DIRECTED[i].want);
        smp_ch.valid <= 1'b0;
        drain_results();

        phase_cfg[0] = '{1'b1, 15'd0, 16'd0, 18'd0};
        phase_cfg[1] = '{1'b0, 15'd32767, 16'd65535, 18'd196602};
        phase_cfg[2] = '{1'b1, 15'd1000, 16'd300, 18'd5000};
        phase_cfg[3] = '{1'($urandom), 15'($urandom_range(0, 20000)),
                         16'($urandom_range(0, 2000)), 18'($urandom_range(0, 196602))};
        phase_cfg[4] = '{1'($urandom), 15'($urandom),
                         16'($urandom), 18'($urandom_range(0, 196602))};
        phase_cfg[5] = '{1'b0, TRIGGER_LEVEL_RST, STABLE_TIME_RST, MOTION_THRESHOLD_RST};
        foreach (phase_cfg[p]) run_phase(phase_cfg[p], 115, p == 2 || p == 4);

        repeat (4) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
